// ----- rtl/ctl_pkg.sv -----
// shared types, constants and character-class helpers for the source tokenizer
// no dependencies; used by the channel interfaces and imported by every rtl module
`default_nettype none

package ctl_pkg;

   localparam int OUT_W      = 24;
   localparam int TYPE_W     = 8;
   localparam int ERR_W      = 3;
   localparam int FIFO_DEPTH = 4;

   typedef enum logic [3:0] {
      MODE_IDLE      = 4'd0,
      MODE_IDENT     = 4'd1,
      MODE_NUMBER    = 4'd2,
      MODE_STRING    = 4'd3,
      MODE_SLASH     = 4'd4,
      MODE_COLON     = 4'd5,
      MODE_LINECMT   = 4'd6,
      MODE_BLOCK     = 4'd7,
      MODE_BLOCKSTAR = 4'd8
   } scan_mode_type;

   typedef enum logic [1:0] {
      ESC_NORMAL    = 2'd0,
      ESC_BACKSLASH = 2'd1,
      ESC_CR        = 2'd2
   } escape_mode_type;

   localparam logic [TYPE_W-1:0] TOK_EOF    = 8'd0;
   localparam logic [TYPE_W-1:0] TOK_IDENT  = 8'd128;
   localparam logic [TYPE_W-1:0] TOK_NUMBER = 8'd129;
   localparam logic [TYPE_W-1:0] TOK_STRING = 8'd130;
   localparam logic [TYPE_W-1:0] TOK_DCOLON = 8'd131;

   localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
   localparam logic [ERR_W-1:0] ERR_EOF_COMMENT = 3'd1;
   localparam logic [ERR_W-1:0] ERR_EOF_STRING  = 3'd2;
   localparam logic [ERR_W-1:0] ERR_NL_STRING   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_INVALID     = 3'd4;

   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_VT     = 8'h0B;
   localparam logic [7:0] CHR_FF     = 8'h0C;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_STAR   = 8'h2A;
   localparam logic [7:0] CHR_SLASH  = 8'h2F;
   localparam logic [7:0] CHR_COLON  = 8'h3A;
   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_UNDER  = 8'h5F;
   localparam logic [7:0] CHR_DEL    = 8'h7F;

   typedef struct packed {
      logic [TYPE_W-1:0] token_type;
      logic [OUT_W-1:0]  begin_offset;
      logic [OUT_W-1:0]  end_offset;
      logic [OUT_W-1:0]  line_no;
      logic [OUT_W-1:0]  column_no;
      logic [ERR_W-1:0]  error_code;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic first_vld;
      logic second_vld;
   } push_ctl_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_letter(c) || is_digit(c) || (c == CHR_UNDER);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_LF) || (c == CHR_VT)
         || (c == CHR_FF) || (c == CHR_CR);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ctl_channels.sv -----
// valid/ready channel interfaces for source bytes and result tokens
// depends on ctl_pkg for payload widths
`default_nettype none

interface ctl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_mark;

   modport source (output valid, output ch, output end_mark, input ready);
   modport sink   (input valid, input ch, input end_mark, output ready);
endinterface

interface ctl_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ctl_pkg::TYPE_W-1:0] token_type;
   logic [ctl_pkg::OUT_W-1:0]  begin_offset;
   logic [ctl_pkg::OUT_W-1:0]  end_offset;
   logic [ctl_pkg::OUT_W-1:0]  line_no;
   logic [ctl_pkg::OUT_W-1:0]  column_no;
   logic [ctl_pkg::ERR_W-1:0]  error_code;
   logic                       last;

   modport source (output valid, output token_type, output begin_offset,
                   output end_offset, output line_no, output column_no,
                   output error_code, output last, input ready);
   modport sink   (input valid, input token_type, input begin_offset,
                   input end_offset, input line_no, input column_no,
                   input error_code, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/c_like_source_tokenizer.sv -----
// streaming c-style tokenizer, one source byte per transaction
// req_chan carries a byte (ch) or an end marker (end_mark); rsp_chan carries
// tokens with type, begin/end byte offset, start line/column, error code and
// a last flag on the final result of each input transaction.
// a byte is taken into an input register and scanned from there once the
// result queue has room, which queues its zero, one or two results; the
// results are registered in the queue and offered on rsp_chan in order.
// throughput is one byte per cycle while the result queue has room;
// a byte is scanned only when the four-entry result queue has two free slots,
// so runs of bytes giving two results each drain at the one-per-cycle output.
// when the receiver stalls the queue fills; once it holds more than two
// results the waiting byte is held and req_chan.ready stays low until the
// queue drains; nothing is lost or repeated.
// reset clears the queue and puts the scanner between tokens at line 1,
// column 1, offset 0; an end marker does the same after its results.
// depends on ctl_pkg, ctl_channels, ctl_lexer and ctl_out_fifo
`default_nettype none

module c_like_source_tokenizer #(
   parameter int POS_BITS = 24
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ctl_req_if.sink    req_chan,
   ctl_rsp_if.source  rsp_chan
);
   import ctl_pkg::*;

   logic         in_vld_ff;
   logic [7:0]   in_ch_ff;
   logic         in_end_ff;
   logic         room;
   logic         take;
   logic         req_fire;
   push_ctl_type push;
   rsp_item_type first_item, second_item, out_item;

   assign take           = in_vld_ff && room;
   assign req_chan.ready = !in_vld_ff || take;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ch_ff  <= req_chan.ch;
         in_end_ff <= req_chan.end_mark;
      end
   end

   ctl_lexer #(
      .POS_BITS (POS_BITS)
   ) u_lexer (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .in_ch       (in_ch_ff),
      .in_end      (in_end_ff),
      .push        (push),
      .first_item  (first_item),
      .second_item (second_item)
   );

   ctl_out_fifo u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .first_item  (first_item),
      .second_item (second_item),
      .room        (room),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_item    (out_item)
   );

   assign rsp_chan.token_type   = out_item.token_type;
   assign rsp_chan.begin_offset = out_item.begin_offset;
   assign rsp_chan.end_offset   = out_item.end_offset;
   assign rsp_chan.line_no      = out_item.line_no;
   assign rsp_chan.column_no    = out_item.column_no;
   assign rsp_chan.error_code   = out_item.error_code;
   assign rsp_chan.last         = out_item.last;

endmodule

`default_nettype wire

// ----- rtl/ctl_lexer.sv -----
// scanner state and per-byte token logic, up to two results per byte
// depends on ctl_pkg
`default_nettype none

module ctl_lexer #(
   parameter int POS_BITS = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire logic [7:0]            in_ch,
   input  wire logic                  in_end,
   output ctl_pkg::push_ctl_type      push,
   output ctl_pkg::rsp_item_type      first_item,
   output ctl_pkg::rsp_item_type      second_item
);
   import ctl_pkg::*;

   localparam logic [POS_BITS-1:0] POS_ZERO = '0;
   localparam logic [POS_BITS-1:0] POS_ONE  = {{(POS_BITS-1){1'b0}}, 1'b1};

   scan_mode_type       mode_ff, mode_in;
   escape_mode_type     esc_ff, esc_in;
   logic [POS_BITS-1:0] off_ff, off_in;
   logic [POS_BITS-1:0] line_ff, line_in;
   logic [POS_BITS-1:0] col_ff, col_in;
   logic [POS_BITS-1:0] tbeg_ff, tbeg_in;
   logic [POS_BITS-1:0] tline_ff, tline_in;
   logic [POS_BITS-1:0] tcol_ff, tcol_in;
   logic                halt_ff, halt_in;

   logic                a_vld, b_vld, redo;
   rsp_item_type        a_item, b_item;

   function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
      return (&v) ? v : v + POS_ONE;
   endfunction

   function automatic logic [OUT_W-1:0] to_out(input logic [POS_BITS-1:0] v);
      logic [OUT_W+POS_BITS-1:0] ext;
      ext = {{OUT_W{1'b0}}, v};
      return ext[OUT_W-1:0];
   endfunction

   function automatic rsp_item_type make_item(
      input logic [TYPE_W-1:0]   t,
      input logic [POS_BITS-1:0] b,
      input logic [POS_BITS-1:0] e,
      input logic [POS_BITS-1:0] l,
      input logic [POS_BITS-1:0] k,
      input logic [ERR_W-1:0]    err
   );
      rsp_item_type r;
      r.token_type   = t;
      r.begin_offset = to_out(b);
      r.end_offset   = to_out(e);
      r.line_no      = to_out(l);
      r.column_no    = to_out(k);
      r.error_code   = err;
      r.last         = 1'b0;
      return r;
   endfunction

   always_comb begin
      mode_in  = mode_ff;
      esc_in   = esc_ff;
      off_in   = off_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      tbeg_in  = tbeg_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      halt_in  = halt_ff;
      a_vld    = 1'b0;
      b_vld    = 1'b0;
      a_item   = '0;
      b_item   = '0;
      redo     = 1'b0;

      if (in_end) begin
         if (!halt_ff) begin
            unique case (mode_ff)
               MODE_IDENT: begin
                  a_vld  = 1'b1;
                  a_item = make_item(TOK_IDENT, tbeg_ff, off_ff, tline_ff, tcol_ff, ERR_NONE);
               end
               MODE_NUMBER: begin
                  a_vld  = 1'b1;
                  a_item = make_item(TOK_NUMBER, tbeg_ff, off_ff, tline_ff, tcol_ff, ERR_NONE);
               end
               MODE_SLASH: begin
                  a_vld  = 1'b1;
                  a_item = make_item(CHR_SLASH, tbeg_ff, sat_inc(tbeg_ff), tline_ff, tcol_ff,
                                     ERR_NONE);
               end
               MODE_COLON: begin
                  a_vld  = 1'b1;
                  a_item = make_item(CHR_COLON, tbeg_ff, sat_inc(tbeg_ff), tline_ff, tcol_ff,
                                     ERR_NONE);
               end
               default: ;
            endcase
            b_vld = 1'b1;
            if (mode_ff == MODE_BLOCK || mode_ff == MODE_BLOCKSTAR)
               b_item = make_item(TOK_EOF, off_ff, off_ff, line_ff, col_ff, ERR_EOF_COMMENT);
            else if (mode_ff == MODE_STRING)
               b_item = make_item(TOK_EOF, off_ff, off_ff, line_ff, col_ff, ERR_EOF_STRING);
            else
               b_item = make_item(TOK_EOF, off_ff, off_ff, line_ff, col_ff, ERR_NONE);
         end
         // end of source returns everything to the reset state
         mode_in  = MODE_IDLE;
         esc_in   = ESC_NORMAL;
         off_in   = POS_ZERO;
         line_in  = POS_ONE;
         col_in   = POS_ONE;
         tbeg_in  = POS_ZERO;
         tline_in = POS_ZERO;
         tcol_in  = POS_ZERO;
         halt_in  = 1'b0;
      end else if (!halt_ff) begin
         unique case (mode_ff)
            MODE_IDENT, MODE_NUMBER: begin
               if (!is_word(in_ch)) begin
                  a_vld   = 1'b1;
                  a_item  = make_item((mode_ff == MODE_IDENT) ? TOK_IDENT : TOK_NUMBER,
                                      tbeg_ff, off_ff, tline_ff, tcol_ff, ERR_NONE);
                  mode_in = MODE_IDLE;
                  redo    = 1'b1;
               end
            end
            MODE_STRING: begin
               priority if (in_ch == CHR_QUOTE) begin
                  if (esc_ff == ESC_BACKSLASH) begin
                     esc_in = ESC_NORMAL;
                  end else begin
                     a_vld   = 1'b1;
                     a_item  = make_item(TOK_STRING, tbeg_ff, sat_inc(off_ff), tline_ff,
                                         tcol_ff, ERR_NONE);
                     mode_in = MODE_IDLE;
                     esc_in  = ESC_NORMAL;
                  end
               end else if (in_ch == CHR_BSLASH) begin
                  esc_in = (esc_ff == ESC_BACKSLASH) ? ESC_NORMAL : ESC_BACKSLASH;
               end else if (in_ch == CHR_LF) begin
                  if (esc_ff != ESC_NORMAL) begin
                     esc_in = ESC_NORMAL;
                  end else begin
                     a_vld   = 1'b1;
                     a_item  = make_item(TOK_EOF, off_ff, off_ff, line_ff, col_ff,
                                         ERR_NL_STRING);
                     halt_in = 1'b1;
                  end
               end else if (in_ch == CHR_CR) begin
                  if (esc_ff == ESC_BACKSLASH) esc_in = ESC_CR;
               end else begin
                  esc_in = ESC_NORMAL;
               end
            end
            MODE_SLASH: begin
               priority if (in_ch == CHR_SLASH) begin
                  mode_in = MODE_LINECMT;
               end else if (in_ch == CHR_STAR) begin
                  mode_in = MODE_BLOCK;
               end else begin
                  a_vld   = 1'b1;
                  a_item  = make_item(CHR_SLASH, tbeg_ff, sat_inc(tbeg_ff), tline_ff, tcol_ff,
                                      ERR_NONE);
                  mode_in = MODE_IDLE;
                  redo    = 1'b1;
               end
            end
            MODE_COLON: begin
               a_vld   = 1'b1;
               mode_in = MODE_IDLE;
               if (in_ch == CHR_COLON) begin
                  a_item = make_item(TOK_DCOLON, tbeg_ff, sat_inc(off_ff), tline_ff, tcol_ff,
                                     ERR_NONE);
               end else begin
                  a_item = make_item(CHR_COLON, tbeg_ff, sat_inc(tbeg_ff), tline_ff, tcol_ff,
                                     ERR_NONE);
                  redo   = 1'b1;
               end
            end
            MODE_LINECMT: begin
               if (in_ch == CHR_LF) mode_in = MODE_IDLE;
            end
            MODE_BLOCK: begin
               if (in_ch == CHR_STAR) mode_in = MODE_BLOCKSTAR;
            end
            MODE_BLOCKSTAR: begin
               if (in_ch == CHR_SLASH) mode_in = MODE_IDLE;
               else if (in_ch != CHR_STAR) mode_in = MODE_BLOCK;
            end
            default: begin
               mode_in = MODE_IDLE;
               redo    = 1'b1;
            end
         endcase

         // byte that ended the previous token, or any byte between tokens
         if (redo && !is_space(in_ch)) begin
            priority if (in_ch == CHR_SLASH || in_ch == CHR_COLON || is_letter(in_ch)
                         || in_ch == CHR_UNDER || is_digit(in_ch) || in_ch == CHR_QUOTE) begin
               tbeg_in  = off_ff;
               tline_in = line_ff;
               tcol_in  = col_ff;
               priority if (in_ch == CHR_SLASH)  mode_in = MODE_SLASH;
               else if (in_ch == CHR_COLON)      mode_in = MODE_COLON;
               else if (is_digit(in_ch))         mode_in = MODE_NUMBER;
               else if (in_ch == CHR_QUOTE) begin
                  mode_in = MODE_STRING;
                  esc_in  = ESC_NORMAL;
               end else                          mode_in = MODE_IDENT;
            end else if (in_ch > CHR_SPACE && in_ch < CHR_DEL) begin
               b_vld  = 1'b1;
               b_item = make_item(in_ch, off_ff, sat_inc(off_ff), line_ff, col_ff, ERR_NONE);
            end else begin
               b_vld   = 1'b1;
               b_item  = make_item(TOK_EOF, off_ff, off_ff, line_ff, col_ff, ERR_INVALID);
               halt_in = 1'b1;
            end
         end

         if (!halt_in) begin
            off_in = sat_inc(off_ff);
            if (in_ch == CHR_LF) begin
               line_in = sat_inc(line_ff);
               col_in  = POS_ONE;
            end else begin
               col_in = sat_inc(col_ff);
            end
         end
      end
   end

   // pack results so a lone one always sits in the first slot
   always_comb begin
      push.first_vld  = take && (a_vld || b_vld);
      push.second_vld = take && a_vld && b_vld;
      first_item      = a_vld ? a_item : b_item;
      second_item     = b_item;
      first_item.last = !(a_vld && b_vld);
      second_item.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         esc_ff   <= ESC_NORMAL;
         off_ff   <= POS_ZERO;
         line_ff  <= POS_ONE;
         col_ff   <= POS_ONE;
         tbeg_ff  <= POS_ZERO;
         tline_ff <= POS_ZERO;
         tcol_ff  <= POS_ZERO;
         halt_ff  <= 1'b0;
      end else if (take) begin
         mode_ff  <= mode_in;
         esc_ff   <= esc_in;
         off_ff   <= off_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         tbeg_ff  <= tbeg_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
         halt_ff  <= halt_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ctl_out_fifo.sv -----
// small result queue taking up to two results per cycle and giving one
// depends on ctl_pkg
`default_nettype none

module ctl_out_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctl_pkg::push_ctl_type push,
   input  wire ctl_pkg::rsp_item_type first_item,
   input  wire ctl_pkg::rsp_item_type second_item,
   output logic                       room,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output ctl_pkg::rsp_item_type      out_item
);
   import ctl_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(FIFO_DEPTH - 2);

   rsp_item_type     mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;
   logic [PTR_W-1:0] wr_next;

   assign room      = cnt_ff <= ROOM_LIMIT;
   assign out_valid = cnt_ff != '0;
   assign out_item  = mem[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign wr_next   = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.first_vld) + PTR_W'(push.second_vld);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      cnt_in    = cnt_ff + CNT_W'(push.first_vld) + CNT_W'(push.second_vld) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first_vld)  mem[wr_ptr_ff] <= first_item;
      if (push.second_vld) mem[wr_next]   <= second_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- tb/c_like_source_tokenizer_tb.sv -----
// testbench for c_like_source_tokenizer: directed and random source streams,
// a token predictor and a result checker; depends on ctl_pkg and ctl_channels
`timescale 1ns / 100ps

module c_like_source_tokenizer_tb;
   import ctl_pkg::*;

   typedef struct packed {
      logic       hold;
      logic       end_mark;
      logic [7:0] ch;
   } source_byte_type;

   logic clock;
   logic reset;

   ctl_req_if req_chan();
   ctl_rsp_if rsp_chan();

   c_like_source_tokenizer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   source_byte_type source_bytes[$];
   rsp_item_type    expected_tokens[$];
   int              errors = 0;

   // predictor state
   scan_mode_type   scan_st;
   escape_mode_type esc_st;
   logic [23:0]     src_offset, src_line, src_column;
   logic [23:0]     tok_offset, tok_line, tok_column;
   logic            dropping;
   rsp_item_type    step_tok[2];
   int              step_cnt;

   // ---------------------------------------------------------------- clock, reset

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.ch       = 8'd0;
      req_chan.end_mark = 1'b0;
      rsp_chan.ready    = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [23:0] bump(input logic [23:0] v);
      return (v == 24'hFFFFFF) ? v : v + 24'd1;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == CHR_SPACE || c == CHR_TAB || c == CHR_LF || c == CHR_VT
         || c == CHR_FF || c == CHR_CR;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_num(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   task automatic clear_scanner();
      scan_st    = MODE_IDLE;
      esc_st     = ESC_NORMAL;
      src_offset = 24'd0;
      src_line   = 24'd1;
      src_column = 24'd1;
      tok_offset = 24'd0;
      tok_line   = 24'd0;
      tok_column = 24'd0;
      dropping   = 1'b0;
   endtask

   task automatic add_token(input logic [7:0] kind, input logic [23:0] b, e, l, k,
                            input logic [2:0] err);
      step_tok[step_cnt] = '{kind, b, e, l, k, err, 1'b0};
      step_cnt++;
   endtask

   task automatic open_token(input scan_mode_type m);
      tok_offset = src_offset;
      tok_line   = src_line;
      tok_column = src_column;
      scan_st    = m;
   endtask

   task automatic begin_token(input logic [7:0] c);
      if (is_blank(c)) begin
      end else if (c == CHR_SLASH) begin
         open_token(MODE_SLASH);
      end else if (c == CHR_COLON) begin
         open_token(MODE_COLON);
      end else if (is_alpha(c) || c == CHR_UNDER) begin
         open_token(MODE_IDENT);
      end else if (is_num(c)) begin
         open_token(MODE_NUMBER);
      end else if (c == CHR_QUOTE) begin
         open_token(MODE_STRING);
         esc_st = ESC_NORMAL;
      end else if (c > CHR_SPACE && c < CHR_DEL) begin
         add_token(c, src_offset, bump(src_offset), src_line, src_column, ERR_NONE);
      end else begin
         add_token(TOK_EOF, src_offset, src_offset, src_line, src_column, ERR_INVALID);
         dropping = 1'b1;
      end
   endtask

   task automatic predict_tokens(input logic [7:0] c, input logic eom);
      logic redo;
      logic [2:0] err;
      redo     = 1'b0;
      step_cnt = 0;
      if (eom) begin
         if (!dropping) begin
            case (scan_st)
               MODE_IDENT, MODE_NUMBER:
                  add_token(scan_st == MODE_IDENT ? TOK_IDENT : TOK_NUMBER, tok_offset,
                            src_offset, tok_line, tok_column, ERR_NONE);
               MODE_SLASH, MODE_COLON:
                  add_token(scan_st == MODE_SLASH ? CHR_SLASH : CHR_COLON, tok_offset,
                            bump(tok_offset), tok_line, tok_column, ERR_NONE);
               default: ;
            endcase
            if (scan_st == MODE_BLOCK || scan_st == MODE_BLOCKSTAR)
               err = ERR_EOF_COMMENT;
            else if (scan_st == MODE_STRING)
               err = ERR_EOF_STRING;
            else
               err = ERR_NONE;
            add_token(TOK_EOF, src_offset, src_offset, src_line, src_column, err);
         end
         clear_scanner();
      end else if (!dropping) begin
         case (scan_st)
            MODE_IDENT, MODE_NUMBER: begin
               if (!(is_alpha(c) || is_num(c) || c == CHR_UNDER)) begin
                  add_token(scan_st == MODE_IDENT ? TOK_IDENT : TOK_NUMBER, tok_offset,
                            src_offset, tok_line, tok_column, ERR_NONE);
                  scan_st = MODE_IDLE;
                  redo    = 1'b1;
               end
            end
            MODE_STRING: begin
               if (c == CHR_QUOTE) begin
                  if (esc_st == ESC_BACKSLASH) begin
                     esc_st = ESC_NORMAL;
                  end else begin
                     add_token(TOK_STRING, tok_offset, bump(src_offset), tok_line,
                               tok_column, ERR_NONE);
                     scan_st = MODE_IDLE;
                     esc_st  = ESC_NORMAL;
                  end
               end else if (c == CHR_BSLASH) begin
                  esc_st = (esc_st == ESC_BACKSLASH) ? ESC_NORMAL : ESC_BACKSLASH;
               end else if (c == CHR_LF) begin
                  if (esc_st != ESC_NORMAL) begin
                     esc_st = ESC_NORMAL;
                  end else begin
                     add_token(TOK_EOF, src_offset, src_offset, src_line, src_column,
                               ERR_NL_STRING);
                     dropping = 1'b1;
                  end
               end else if (c == CHR_CR) begin
                  if (esc_st == ESC_BACKSLASH)
                     esc_st = ESC_CR;
               end else begin
                  esc_st = ESC_NORMAL;
               end
            end
            MODE_SLASH: begin
               if (c == CHR_SLASH) begin
                  scan_st = MODE_LINECMT;
               end else if (c == CHR_STAR) begin
                  scan_st = MODE_BLOCK;
               end else begin
                  add_token(CHR_SLASH, tok_offset, bump(tok_offset), tok_line, tok_column,
                            ERR_NONE);
                  scan_st = MODE_IDLE;
                  redo    = 1'b1;
               end
            end
            MODE_COLON: begin
               if (c == CHR_COLON) begin
                  add_token(TOK_DCOLON, tok_offset, bump(src_offset), tok_line, tok_column,
                            ERR_NONE);
               end else begin
                  add_token(CHR_COLON, tok_offset, bump(tok_offset), tok_line, tok_column,
                            ERR_NONE);
                  redo = 1'b1;
               end
               scan_st = MODE_IDLE;
            end
            MODE_LINECMT: if (c == CHR_LF) scan_st = MODE_IDLE;
            MODE_BLOCK:   if (c == CHR_STAR) scan_st = MODE_BLOCKSTAR;
            MODE_BLOCKSTAR: begin
               if (c == CHR_SLASH)
                  scan_st = MODE_IDLE;
               else if (c != CHR_STAR)
                  scan_st = MODE_BLOCK;
            end
            default: begin
               scan_st = MODE_IDLE;
               redo    = 1'b1;
            end
         endcase
         if (redo)
            begin_token(c);
         if (!dropping) begin
            src_offset = bump(src_offset);
            if (c == CHR_LF) begin
               src_line   = bump(src_line);
               src_column = 24'd1;
            end else begin
               src_column = bump(src_column);
            end
         end
      end
      for (int i = 0; i < step_cnt; i++) begin
         if (i == step_cnt - 1)
            step_tok[i].last = 1'b1;
         expected_tokens.push_back(step_tok[i]);
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic push_byte(input logic [7:0] c);
      source_bytes.push_back('{1'b0, 1'b0, c});
   endtask

   task automatic push_eof();
      source_bytes.push_back('{1'b0, 1'b1, 8'($urandom_range(0, 255))});
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i]);
   endtask

   function automatic logic [7:0] word_char();
      int k;
      k = $urandom_range(0, 62);
      if (k < 26) return 8'("a" + k);
      if (k < 52) return 8'("A" + k - 26);
      if (k < 62) return 8'("0" + k - 52);
      return CHR_UNDER;
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 5))
         0: return CHR_SPACE;
         1: return CHR_TAB;
         2: return CHR_LF;
         3: return CHR_VT;
         4: return CHR_FF;
         default: return CHR_CR;
      endcase
   endfunction

   task automatic gen_string_body();
      int pieces;
      logic [7:0] b;
      pieces = $urandom_range(0, 8);
      for (int i = 0; i < pieces; i++) begin
         case ($urandom_range(0, 9))
            0: push_text("\\\\");
            1: push_text("\\\"");
            2: begin push_byte(CHR_BSLASH); push_byte(CHR_CR); push_byte(CHR_LF); end
            3: begin push_byte(CHR_BSLASH); push_byte(CHR_LF); end
            4: begin push_byte(CHR_BSLASH); push_byte(CHR_CR); push_byte(word_char()); end
            5: push_byte(8'($urandom_range(128, 255)));
            default: begin
               b = 8'($urandom_range(32, 126));
               if (b == CHR_QUOTE || b == CHR_BSLASH)
                  b = "s";
               push_byte(b);
            end
         endcase
      end
   endtask

   task automatic gen_source();
      int frags, k, len;
      logic [7:0] b;
      frags = $urandom_range(2, 12);
      for (int f = 0; f < frags; f++) begin
         k = $urandom_range(0, 99);
         if (k < 18) begin
            push_byte($urandom_range(0, 1) ? CHR_UNDER : 8'("a" + $urandom_range(0, 25)));
            len = $urandom_range(0, 5);
            for (int i = 0; i < len; i++) push_byte(word_char());
         end else if (k < 30) begin
            push_byte(8'("0" + $urandom_range(0, 9)));
            len = $urandom_range(0, 4);
            for (int i = 0; i < len; i++) push_byte(word_char());
         end else if (k < 45) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) push_byte(blank_char());
         end else if (k < 55) begin
            push_byte(8'($urandom_range(33, 126)));
         end else if (k < 60) begin
            push_text("::");
         end else if (k < 64) begin
            push_byte(CHR_COLON);
         end else if (k < 68) begin
            push_byte(CHR_SLASH);
         end else if (k < 74) begin
            push_text("//");
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++) begin
               b = 8'($urandom_range(0, 255));
               push_byte(b == CHR_LF ? 8'h41 : b);
            end
            push_byte(CHR_LF);
         end else if (k < 82) begin
            push_text("/*");
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 3))
                  0: push_byte(CHR_STAR);
                  1: push_byte(CHR_SLASH);
                  2: push_byte(blank_char());
                  default: push_byte(8'($urandom_range(0, 255)));
               endcase
            end
            push_text("*/");
         end else if (k < 94) begin
            push_byte(CHR_QUOTE);
            gen_string_body();
            push_byte(CHR_QUOTE);
         end else if (k < 97) begin
            case ($urandom_range(0, 3))
               0: push_byte(8'($urandom_range(0, 8)));
               1: push_byte(8'($urandom_range(14, 31)));
               2: push_byte(CHR_DEL);
               default: push_byte(8'($urandom_range(128, 255)));
            endcase
         end else begin
            // raw newline inside a string
            push_byte(CHR_QUOTE);
            gen_string_body();
            push_byte(CHR_LF);
         end
      end
      // source sometimes cut off inside a comment or a string, or after a random byte
      case ($urandom_range(0, 11))
         0: begin push_text("/*"); push_byte(word_char()); end
         1: begin push_byte(CHR_QUOTE); gen_string_body(); end
         2: push_byte(8'($urandom_range(0, 255)));
         default: ;
      endcase
      push_eof();
   endtask

   initial begin
      clear_scanner();
      // identifier, number, colon then a slash left pending at end of source
      push_text("_a9 7:/");
      push_eof();
      // string escapes: double backslash, escaped quote, backslash cr lf
      push_text("\"\\\\\\\"\\");
      push_byte(CHR_CR);
      push_text("\n\"::");
      push_eof();
      // block comment whose opening star does not close it, then a line comment
      push_text("/*/*");
      push_byte(CHR_TAB);
      push_byte(CHR_VT);
      push_byte(CHR_FF);
      push_text("**/// c\n!~");
      push_eof();
      push_text("/*/");
      push_eof();
      push_text("\"x\nq");
      push_eof();
      push_text("\"x");
      push_eof();
      push_byte(8'h00);
      push_eof();
      push_byte(8'hFF);
      push_eof();
      push_byte(CHR_DEL);
      push_eof();
      while (source_bytes.size() < 250)
         gen_source();
      source_bytes.push_back('{1'b1, 1'b0, 8'd0});
      while (source_bytes.size() < 480)
         gen_source();
   end

   // ---------------------------------------------------------------- driver

   logic taken = 1'b0;
   int   burst_left = 0;
   int   gap_left = 0;

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         predict_tokens(req_chan.ch, req_chan.end_mark);
         taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      source_byte_type item;
      logic            next_valid;
      next_valid = req_chan.valid;
      item       = '{1'b0, req_chan.end_mark, req_chan.ch};
      if (!reset && (!req_chan.valid || taken)) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (source_bytes.size() != 0) begin
            if (source_bytes[0].hold) begin
               // let the block run dry before carrying on
               if (expected_tokens.size() == 0)
                  void'(source_bytes.pop_front());
            end else begin
               item       = source_bytes.pop_front();
               next_valid = 1'b1;
               if (burst_left == 0)
                  burst_left = $urandom_range(1, 40);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end
      end
      taken = 1'b0;
      req_chan.valid    <= next_valid;
      req_chan.ch       <= item.ch;
      req_chan.end_mark <= item.end_mark;
   end

   // ---------------------------------------------------------------- monitor

   int rx_cycle = 0;
   int rx_style = 0;
   int stall_left = 0;

   always @(negedge clock) begin
      logic rdy;
      rx_cycle++;
      if (rx_cycle % 256 == 0)
         rx_style = $urandom_range(0, 3);
      case (rx_style)
         0: rdy = 1'b1;
         1: rdy = ($urandom_range(0, 3) != 0);
         2: rdy = (rx_cycle % 5) < 2;
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rdy = 1'b0;
            end else begin
               rdy = 1'b1;
               if ($urandom_range(0, 7) == 0)
                  stall_left = $urandom_range(5, 25);
            end
         end
      endcase
      rsp_chan.ready <= rdy;
   end

   task automatic check_field(input string name, input logic [23:0] want, got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t ns: unexpected token, expected none, got type %0d", $time,
                     rsp_chan.token_type);
            errors++;
         end else begin
            want = expected_tokens.pop_front();
            check_field("token_type", 24'(want.token_type), 24'(rsp_chan.token_type));
            check_field("begin_offset", want.begin_offset, rsp_chan.begin_offset);
            check_field("end_offset", want.end_offset, rsp_chan.end_offset);
            check_field("line_no", want.line_no, rsp_chan.line_no);
            check_field("column_no", want.column_no, rsp_chan.column_no);
            check_field("error_code", 24'(want.error_code), 24'(rsp_chan.error_code));
            check_field("last", 24'(want.last), 24'(rsp_chan.last));
         end
      end
   end

   // ---------------------------------------------------------------- end of run

   initial begin
      @(negedge clock);
      while (reset) @(posedge clock);
      while (source_bytes.size() != 0 || req_chan.valid) @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d tokens outstanding", expected_tokens.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
